@@ src/lmt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lmt_pkg: shared types and constants for LCD mode timing with video DMA
// Line and dot timing constants, mode codes, command codes, register indexes
// and the state, configuration and result records passed between modules.
// ----------------------------------------------------------------------------
package lmt_pkg;

  // Timing
  localparam logic [8:0] DOTS_PER_LINE   = 9'd456;
  localparam logic [7:0] VISIBLE_LINES   = 8'd144;
  localparam logic [7:0] LINES_PER_FRAME = VISIBLE_LINES + 8'd10;
  localparam logic [8:0] OAM_DOTS        = 9'd80;
  localparam logic [8:0] DRAW_DOTS       = 9'd172;
  localparam logic [8:0] DRAW_END        = OAM_DOTS + DRAW_DOTS;

  // DMA
  localparam logic [4:0]  BURST_BYTES = 5'd16;
  localparam logic [15:0] SRC_MASK    = 16'hfff0;
  localparam logic [15:0] DST_MASK    = 16'h1ff0;
  localparam logic [15:0] VRAM_BASE   = 16'h8000;

  // PPU modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  // Input commands
  localparam logic [1:0] FUNC_DOT       = 2'd0;
  localparam logic [1:0] FUNC_GDMA      = 2'd1;
  localparam logic [1:0] FUNC_HDMA      = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LCD_ON        = 3'd0;
  localparam logic [2:0] CFG_LINE_COMPARE  = 3'd1;
  localparam logic [2:0] CFG_IRQ_COMPARE   = 3'd2;
  localparam logic [2:0] CFG_IRQ_HBLANK    = 3'd3;
  localparam logic [2:0] CFG_IRQ_VBLANK    = 3'd4;
  localparam logic [2:0] CFG_IRQ_OAM       = 3'd5;

  typedef struct packed {
    logic        lcd_on;
    logic [7:0]  line_compare;
    logic        irq_on_compare;
    logic        irq_on_hblank;
    logic        irq_on_vblank;
    logic        irq_on_oam;
  } lmt_cfg_t;

  typedef struct packed {
    logic [8:0]  dot_count;
    logic [7:0]  line_count;
    logic [1:0]  mode;
    logic        coincide;
    logic        dma_on;
    logic        dma_is_hblank;
    logic [11:0] dma_left;
    logic [15:0] dma_src;
    logic [15:0] dma_dst;
    logic [4:0]  burst_left;
    logic        dma_halt;
  } lmt_state_t;

  typedef struct packed {
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic        halt_out;
    logic [7:0]  current_line;
    logic [1:0]  lcd_mode;
    logic        vblank_irq;
    logic        stat_irq;
    logic        coincident;
    logic        frame_done;
    logic        draw_row;
    logic [11:0] dma_remaining;
  } lmt_result_t;

endpackage
`default_nettype wire

@@ src/lmt_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lmt_step: next-state and result logic for one transaction
// Applies a DMA start or one dot tick to the timing and DMA state, producing
// the updated state and the result record; an unused command changes no state.
// ----------------------------------------------------------------------------
module lmt_step (
  input  var lmt_pkg::lmt_state_t  state_i,
  input  var lmt_pkg::lmt_cfg_t    cfg_i,
  input  wire logic [1:0]          func_i,
  input  wire logic [1:0]          sub_step_i,
  input  wire logic                cpu_halted_i,
  input  wire logic [15:0]         dma_source_i,
  input  wire logic [15:0]         dma_dest_i,
  input  wire logic [6:0]          dma_blocks_i,
  output lmt_pkg::lmt_state_t      state_o,
  output lmt_pkg::lmt_result_t     result_o
);
  import lmt_pkg::*;

  lmt_state_t  s;
  lmt_result_t r;
  logic        even;
  logic        halted;
  logic [1:0]  old_mode;
  logic [7:0]  blocks_p1;
  logic [7:0]  line_inc;

  always_comb begin
    s         = state_i;
    r         = '0;
    even      = ~sub_step_i[0];
    halted    = cpu_halted_i | state_i.dma_halt;
    old_mode  = state_i.mode;
    blocks_p1 = {1'b0, dma_blocks_i} + 8'd1;
    line_inc  = state_i.line_count + 8'd1;

    unique case (func_i)
      FUNC_GDMA, FUNC_HDMA: begin
        // start (or restart) a transfer
        s.dma_on        = 1'b1;
        s.dma_is_hblank = (func_i == FUNC_HDMA);
        s.dma_left      = {blocks_p1, 4'd0};
        s.dma_src       = dma_source_i & SRC_MASK;
        s.dma_dst       = VRAM_BASE + (dma_dest_i & DST_MASK);
        s.burst_left    = 5'd0;
        s.dma_halt      = (func_i == FUNC_GDMA);
      end
      FUNC_DOT: begin
        // general DMA: one byte per even dot while halted
        if (even && halted && s.dma_on && !s.dma_is_hblank) begin
          r.copy_valid  = 1'b1;
          r.copy_source = s.dma_src;
          r.copy_dest   = s.dma_dst;
          s.dma_src     = s.dma_src + 16'd1;
          s.dma_dst     = s.dma_dst + 16'd1;
          if (s.dma_left != 12'd0) s.dma_left = s.dma_left - 12'd1;
          if (s.dma_left == 12'd0) begin
            s.dma_halt = 1'b0;
            s.dma_on   = 1'b0;
          end
        end

        if (!cfg_i.lcd_on) begin
          s.dot_count  = '0;
          s.line_count = '0;
          s.mode       = MODE_HBLANK;
        end else begin
          // HBlank DMA burst byte
          if (even && old_mode == MODE_HBLANK && !halted && s.burst_left != 5'd0 &&
              s.dma_on && s.dma_is_hblank) begin
            r.copy_valid  = 1'b1;
            r.copy_source = s.dma_src;
            r.copy_dest   = s.dma_dst;
            s.dma_src     = s.dma_src + 16'd1;
            s.dma_dst     = s.dma_dst + 16'd1;
            if (s.dma_left != 12'd0) s.dma_left = s.dma_left - 12'd1;
            s.burst_left  = s.burst_left - 5'd1;
            if (s.dma_left == 12'd0) begin
              s.dma_on     = 1'b0;
              s.burst_left = 5'd0;
            end
          end

          // dot and line counters
          s.dot_count = s.dot_count + 9'd1;
          if (s.dot_count >= DOTS_PER_LINE) begin
            s.line_count = (line_inc >= LINES_PER_FRAME) ? 8'd0 : line_inc;
            s.coincide   = (s.line_count == cfg_i.line_compare);
            if (s.coincide && cfg_i.irq_on_compare) r.stat_irq = 1'b1;
            s.dot_count  = '0;
          end

          // mode selection and entry events
          if (s.line_count >= VISIBLE_LINES) begin
            if (old_mode != MODE_VBLANK) begin
              s.mode       = MODE_VBLANK;
              r.vblank_irq = 1'b1;
              if (cfg_i.irq_on_vblank) r.stat_irq = 1'b1;
              r.frame_done = 1'b1;
            end
          end else if (s.dot_count < OAM_DOTS) begin
            if (old_mode != MODE_OAM) begin
              s.mode = MODE_OAM;
              if (cfg_i.irq_on_oam) r.stat_irq = 1'b1;
            end
          end else if (s.dot_count <= DRAW_END) begin
            s.mode = MODE_DRAW;
          end else if (old_mode != MODE_HBLANK) begin
            s.mode = MODE_HBLANK;
            if (cfg_i.irq_on_hblank) r.stat_irq = 1'b1;
            if (s.dma_on && s.dma_is_hblank && s.dma_left != 12'd0)
              s.burst_left = (s.dma_left < 12'd16) ? s.dma_left[4:0] : BURST_BYTES;
            r.draw_row = 1'b1;
          end
        end
      end
      default: begin
        // unused command: state unchanged
      end
    endcase

    r.halt_out      = s.dma_halt;
    r.current_line  = s.line_count;
    r.lcd_mode      = s.mode;
    r.coincident    = s.coincide;
    r.dma_remaining = s.dma_on ? s.dma_left : 12'd0;
  end

  assign state_o  = s;
  assign result_o = r;

endmodule
`default_nettype wire

@@ src/lcd_mode_timing_with_dma_unit.sv @@
`default_nettype none
// An accepted transaction's result is registered and reaches out_* next cycle.
// Throughput: one transaction per cycle while in_stall is low; state update
// and result record are computed in one pass, stored at the accepting edge.
// in_stall rises only while a result waits and out_stall is high.
// Reset (synchronous, rst_n low): all timing, DMA and configuration state is 0.
// ----------------------------------------------------------------------------
// lcd_mode_timing_with_dma_unit: LCD mode timing with video-memory DMA
// Counts dots and lines, tracks PPU mode, raises interrupts and steps general
// and HBlank DMA transfers, one result per input transaction.
// ----------------------------------------------------------------------------
module lcd_mode_timing_with_dma_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [1:0]  in_sub_step,
  input  wire logic        in_cpu_halted,
  input  wire logic [15:0] in_dma_source,
  input  wire logic [15:0] in_dma_dest,
  input  wire logic [6:0]  in_dma_blocks,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_copy_valid,
  output logic [15:0]      out_copy_source,
  output logic [15:0]      out_copy_dest,
  output logic             out_halt_out,
  output logic [7:0]       out_current_line,
  output logic [1:0]       out_lcd_mode,
  output logic             out_vblank_irq,
  output logic             out_stat_irq,
  output logic             out_coincident,
  output logic             out_frame_done,
  output logic             out_draw_row,
  output logic [11:0]      out_dma_remaining
);
  import lmt_pkg::*;

  lmt_cfg_t    cfg_r;
  lmt_state_t  state_r;
  lmt_state_t  step_state;
  lmt_state_t  state_nxt;
  lmt_result_t result_nxt;
  lmt_result_t result_r;
  logic        out_valid_r;
  logic        in_take;
  logic        cfg_take;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign in_stall  = out_valid_r & out_stall;
  assign in_take   = in_valid & ~in_stall;

  lmt_step u_step (
    .state_i      (state_r),
    .cfg_i        (cfg_r),
    .func_i       (in_func),
    .sub_step_i   (in_sub_step),
    .cpu_halted_i (in_cpu_halted),
    .dma_source_i (in_dma_source),
    .dma_dest_i   (in_dma_dest),
    .dma_blocks_i (in_dma_blocks),
    .state_o      (step_state),
    .result_o     (result_nxt)
  );

  // next timing/DMA state; a compare write recomputes the coincidence flag
  always_comb begin
    state_nxt = in_take ? step_state : state_r;
    if (cfg_take && cfg_index == CFG_LINE_COMPARE) begin
      state_nxt.coincide = (state_r.line_count == cfg_data);
    end
  end

  // configuration registers and timing/DMA state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '0;
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_take) begin
        unique case (cfg_index)
          CFG_LCD_ON:       cfg_r.lcd_on         <= cfg_data[0];
          CFG_LINE_COMPARE: cfg_r.line_compare   <= cfg_data;
          CFG_IRQ_COMPARE:  cfg_r.irq_on_compare <= cfg_data[0];
          CFG_IRQ_HBLANK:   cfg_r.irq_on_hblank  <= cfg_data[0];
          CFG_IRQ_VBLANK:   cfg_r.irq_on_vblank  <= cfg_data[0];
          CFG_IRQ_OAM:      cfg_r.irq_on_oam     <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_copy_valid    = result_r.copy_valid;
  assign out_copy_source   = result_r.copy_source;
  assign out_copy_dest     = result_r.copy_dest;
  assign out_halt_out      = result_r.halt_out;
  assign out_current_line  = result_r.current_line;
  assign out_lcd_mode      = result_r.lcd_mode;
  assign out_vblank_irq    = result_r.vblank_irq;
  assign out_stat_irq      = result_r.stat_irq;
  assign out_coincident    = result_r.coincident;
  assign out_frame_done    = result_r.frame_done;
  assign out_draw_row      = result_r.draw_row;
  assign out_dma_remaining = result_r.dma_remaining;

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for lcd_mode_timing_with_dma_unit
// Runs a short table of directed commands, a dot sweep across a line boundary
// and several random phases under different register settings. Each result
// is compared field by field with its table row or a cycle-accurate predictor.
// ----------------------------------------------------------------------------
module tb;
  import lmt_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] FUNC_SPARE   = 2'd3;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam int unsigned ROWS           = 18;
  localparam int unsigned ON_FROM        = 11;
  localparam int unsigned SWEEP_ITEMS    = 600;
  localparam int unsigned SWEEP_ODDS     = 3000;
  localparam int unsigned RANDOM_ODDS    = 40;
  localparam int unsigned SQUEEZE_AT     = ROWS + 1 + SWEEP_ITEMS + 150;
  localparam int unsigned SQUEEZE_CYCLES = 200;
  localparam int unsigned MAX_REPORTS    = 40;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  sub_step;
    logic        halted;
    logic [15:0] src;
    logic [15:0] dst;
    logic [6:0]  blocks;
  } lcd_cmd_t;

  typedef struct packed {
    lcd_cmd_t    cmd;
    logic        has_want;
    lmt_result_t want;
  } step_row_t;

  // Directed commands; rows with has_want set carry their result literally
  localparam step_row_t BOOT_ROWS [ROWS] = '{
    '{'{FUNC_DOT,   2'd0, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b1, '0},
    '{'{FUNC_SPARE, 2'd3, 1'b1, 16'hffff, 16'hffff, 7'h7f}, 1'b1, '0},
    '{'{FUNC_GDMA,  2'd3, 1'b1, 16'hffff, 16'hffff, 7'h7f}, 1'b1,
      '{halt_out:1'b1, dma_remaining:12'd2048, default:0}},
    '{'{FUNC_DOT,   2'd1, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b1,
      '{halt_out:1'b1, dma_remaining:12'd2048, default:0}},
    '{'{FUNC_DOT,   2'd0, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b1,
      '{copy_valid:1'b1, copy_source:16'hfff0, copy_dest:16'h9ff0,
        halt_out:1'b1, dma_remaining:12'd2047, default:0}},
    '{'{FUNC_DOT,   2'd2, 1'b1, 16'h0000, 16'h0000, 7'h00}, 1'b1,
      '{copy_valid:1'b1, copy_source:16'hfff1, copy_dest:16'h9ff1,
        halt_out:1'b1, dma_remaining:12'd2046, default:0}},
    '{'{FUNC_GDMA,  2'd0, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b1,
      '{halt_out:1'b1, dma_remaining:12'd16, default:0}},
    '{'{FUNC_DOT,   2'd0, 1'b1, 16'h0000, 16'h0000, 7'h00}, 1'b1,
      '{copy_valid:1'b1, copy_source:16'h0000, copy_dest:16'h8000,
        halt_out:1'b1, dma_remaining:12'd15, default:0}},
    '{'{FUNC_HDMA,  2'd1, 1'b0, 16'h1234, 16'h0000, 7'h01}, 1'b1,
      '{dma_remaining:12'd32, default:0}},
    '{'{FUNC_DOT,   2'd0, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b1,
      '{dma_remaining:12'd32, default:0}},
    '{'{FUNC_SPARE, 2'd0, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b1,
      '{dma_remaining:12'd32, default:0}},
    // LCD on from here
    '{'{FUNC_DOT,   2'd0, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b1,
      '{lcd_mode:MODE_OAM, stat_irq:1'b1, coincident:1'b1,
        dma_remaining:12'd32, default:0}},
    '{'{FUNC_DOT,   2'd3, 1'b1, 16'hffff, 16'hffff, 7'h7f}, 1'b0, '0},
    '{'{FUNC_GDMA,  2'd0, 1'b0, 16'h8000, 16'h1ff0, 7'h02}, 1'b0, '0},
    '{'{FUNC_DOT,   2'd0, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b0, '0},
    '{'{FUNC_HDMA,  2'd2, 1'b1, 16'hfff0, 16'hfff0, 7'h7f}, 1'b0, '0},
    '{'{FUNC_DOT,   2'd2, 1'b0, 16'h0000, 16'h0000, 7'h00}, 1'b0, '0},
    '{'{FUNC_SPARE, 2'd1, 1'b0, 16'hffff, 16'hffff, 7'h7f}, 1'b0, '0}
  };

  // Register settings: {lcd_on, compare, irq compare, hblank, vblank, oam}
  localparam lmt_cfg_t PHASE_REGS [6] = '{
    '{1'b1, 8'd0,   1'b1, 1'b1, 1'b1, 1'b1},
    '{1'b1, 8'd150, 1'b1, 1'b0, 1'b1, 1'b0},
    '{1'b1, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd2,   1'b1, 1'b1, 1'b0, 1'b1},
    '{1'b0, 8'd0,   1'b1, 1'b1, 1'b1, 1'b1},
    '{1'b1, 8'd1,   1'b1, 1'b1, 1'b1, 1'b1}
  };
  localparam int unsigned PHASE_ITEMS [4] = '{300, 300, 300, 400};

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [1:0]  in_sub_step;
  logic        in_cpu_halted;
  logic [15:0] in_dma_source;
  logic [15:0] in_dma_dest;
  logic [6:0]  in_dma_blocks;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_copy_valid;
  logic [15:0] out_copy_source;
  logic [15:0] out_copy_dest;
  logic        out_halt_out;
  logic [7:0]  out_current_line;
  logic [1:0]  out_lcd_mode;
  logic        out_vblank_irq;
  logic        out_stat_irq;
  logic        out_coincident;
  logic        out_frame_done;
  logic        out_draw_row;
  logic [11:0] out_dma_remaining;

  // Predictor state and scoreboard
  lmt_state_t  lcd_tim;
  lmt_cfg_t    lcd_regs;
  lmt_result_t pending_results [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned sink_wait    = 0;
  bit          squeeze_done = 1'b0;
  bit          pace_on      = 1'b1;

  lcd_mode_timing_with_dma_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_sub_step       (in_sub_step),
    .in_cpu_halted     (in_cpu_halted),
    .in_dma_source     (in_dma_source),
    .in_dma_dest       (in_dma_dest),
    .in_dma_blocks     (in_dma_blocks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_copy_valid    (out_copy_valid),
    .out_copy_source   (out_copy_source),
    .out_copy_dest     (out_copy_dest),
    .out_halt_out      (out_halt_out),
    .out_current_line  (out_current_line),
    .out_lcd_mode      (out_lcd_mode),
    .out_vblank_irq    (out_vblank_irq),
    .out_stat_irq      (out_stat_irq),
    .out_coincident    (out_coincident),
    .out_frame_done    (out_frame_done),
    .out_draw_row      (out_draw_row),
    .out_dma_remaining (out_dma_remaining)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hang guard
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One DMA byte: report the addresses, then step both pointers and the count
  task automatic take_copy(inout lmt_result_t r);
    r.copy_valid  = 1'b1;
    r.copy_source = lcd_tim.dma_src;
    r.copy_dest   = lcd_tim.dma_dst;
    lcd_tim.dma_src = lcd_tim.dma_src + 16'd1;
    lcd_tim.dma_dst = lcd_tim.dma_dst + 16'd1;
    if (lcd_tim.dma_left != 12'd0) lcd_tim.dma_left = lcd_tim.dma_left - 12'd1;
  endtask

  // Dot timing, mode tracking and DMA stepping for one command
  task automatic advance_timing(input lcd_cmd_t c, output lmt_result_t r);
    logic       even;
    logic       halted;
    logic [1:0] mode_was;
    r = '0;
    even   = ~c.sub_step[0];
    halted = c.halted | lcd_tim.dma_halt;
    if (c.func == FUNC_GDMA || c.func == FUNC_HDMA) begin
      lcd_tim.dma_on        = 1'b1;
      lcd_tim.dma_is_hblank = (c.func == FUNC_HDMA);
      lcd_tim.dma_left      = ({5'd0, c.blocks} + 12'd1) << 4;
      lcd_tim.dma_src       = c.src & SRC_MASK;
      lcd_tim.dma_dst       = VRAM_BASE + (c.dst & DST_MASK);
      lcd_tim.burst_left    = '0;
      lcd_tim.dma_halt      = (c.func == FUNC_GDMA);
    end else if (c.func == FUNC_DOT) begin
      // general DMA runs only while the processor is halted
      if (even && halted && lcd_tim.dma_on && !lcd_tim.dma_is_hblank) begin
        take_copy(r);
        if (lcd_tim.dma_left == 12'd0) begin
          lcd_tim.dma_halt = 1'b0;
          lcd_tim.dma_on   = 1'b0;
        end
      end
      if (!lcd_regs.lcd_on) begin
        lcd_tim.dot_count  = '0;
        lcd_tim.line_count = '0;
        lcd_tim.mode       = MODE_HBLANK;
      end else begin
        mode_was = lcd_tim.mode;
        // HBlank burst bytes
        if (even && mode_was == MODE_HBLANK && !halted && lcd_tim.burst_left != 5'd0 &&
            lcd_tim.dma_on && lcd_tim.dma_is_hblank) begin
          take_copy(r);
          lcd_tim.burst_left = lcd_tim.burst_left - 5'd1;
          if (lcd_tim.dma_left == 12'd0) begin
            lcd_tim.dma_on     = 1'b0;
            lcd_tim.burst_left = '0;
          end
        end
        // dot and line counters
        lcd_tim.dot_count = lcd_tim.dot_count + 9'd1;
        if (lcd_tim.dot_count >= DOTS_PER_LINE) begin
          lcd_tim.line_count = (lcd_tim.line_count >= LINES_PER_FRAME - 8'd1) ?
                               8'd0 : lcd_tim.line_count + 8'd1;
          lcd_tim.coincide = (lcd_tim.line_count == lcd_regs.line_compare);
          if (lcd_tim.coincide && lcd_regs.irq_on_compare) r.stat_irq = 1'b1;
          lcd_tim.dot_count = '0;
        end
        // mode selection and entry events
        if (lcd_tim.line_count >= VISIBLE_LINES) begin
          if (mode_was != MODE_VBLANK) begin
            lcd_tim.mode = MODE_VBLANK;
            r.vblank_irq = 1'b1;
            r.frame_done = 1'b1;
            if (lcd_regs.irq_on_vblank) r.stat_irq = 1'b1;
          end
        end else if (lcd_tim.dot_count < OAM_DOTS) begin
          if (mode_was != MODE_OAM) begin
            lcd_tim.mode = MODE_OAM;
            if (lcd_regs.irq_on_oam) r.stat_irq = 1'b1;
          end
        end else if (lcd_tim.dot_count <= DRAW_END) begin
          lcd_tim.mode = MODE_DRAW;
        end else if (mode_was != MODE_HBLANK) begin
          lcd_tim.mode = MODE_HBLANK;
          r.draw_row   = 1'b1;
          if (lcd_regs.irq_on_hblank) r.stat_irq = 1'b1;
          if (lcd_tim.dma_on && lcd_tim.dma_is_hblank && lcd_tim.dma_left != 12'd0)
            lcd_tim.burst_left = (lcd_tim.dma_left < 12'(BURST_BYTES)) ?
                                 lcd_tim.dma_left[4:0] : BURST_BYTES;
        end
      end
    end
    r.halt_out      = lcd_tim.dma_halt;
    r.current_line  = lcd_tim.line_count;
    r.lcd_mode      = lcd_tim.mode;
    r.coincident    = lcd_tim.coincide;
    r.dma_remaining = lcd_tim.dma_on ? lcd_tim.dma_left : 12'd0;
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      CFG_LCD_ON: lcd_regs.lcd_on = val[0];
      CFG_LINE_COMPARE: begin
        lcd_regs.line_compare = val;
        lcd_tim.coincide = (lcd_tim.line_count == val);
      end
      CFG_IRQ_COMPARE: lcd_regs.irq_on_compare = val[0];
      CFG_IRQ_HBLANK:  lcd_regs.irq_on_hblank  = val[0];
      CFG_IRQ_VBLANK:  lcd_regs.irq_on_vblank  = val[0];
      CFG_IRQ_OAM:     lcd_regs.irq_on_oam     = val[0];
      default: ;
    endcase
  endtask

  // Register write; called at a falling edge, returns at one
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
  endtask

  // Full register load; unused indexes get junk that must be ignored
  task automatic load_regs(input lmt_cfg_t s);
    write_reg(CFG_SPARE_LO, 8'($urandom));
    write_reg(CFG_SPARE_HI, 8'($urandom));
    write_reg(CFG_LCD_ON, {7'($urandom), s.lcd_on});
    write_reg(CFG_LINE_COMPARE, s.line_compare);
    write_reg(CFG_IRQ_COMPARE, {7'($urandom), s.irq_on_compare});
    write_reg(CFG_IRQ_HBLANK, {7'($urandom), s.irq_on_hblank});
    write_reg(CFG_IRQ_VBLANK, {7'($urandom), s.irq_on_vblank});
    write_reg(CFG_IRQ_OAM, {7'($urandom), s.irq_on_oam});
    cfg_valid <= 1'b0;
  endtask

  // Send one command transaction; called at a falling edge, returns at one
  task automatic push_cmd(input lcd_cmd_t c, input logic has_want, input lmt_result_t want);
    lmt_result_t guess;
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= c.func;
    in_sub_step   <= c.sub_step;
    in_cpu_halted <= c.halted;
    in_dma_source <= c.src;
    in_dma_dest   <= c.dst;
    in_dma_blocks <= c.blocks;
    do @(posedge clk); while (in_stall);
    advance_timing(c, guess);
    pending_results.insert(pending_results.size(), has_want ? want : guess);
    @(negedge clk);
  endtask

  // Mostly dot ticks; DMA starts and the unused code at about 1 in odds each
  function automatic lcd_cmd_t random_cmd(input int unsigned odds);
    lcd_cmd_t    c;
    int unsigned pick;
    pick = $urandom_range(0, odds - 1);
    case (pick)
      0:       c.func = FUNC_HDMA;
      1:       c.func = FUNC_GDMA;
      2:       c.func = FUNC_SPARE;
      default: c.func = FUNC_DOT;
    endcase
    c.sub_step = 2'($urandom_range(0, 3));
    c.halted   = ($urandom_range(0, 4) == 0);
    c.src      = 16'($urandom);
    c.dst      = 16'($urandom);
    c.blocks   = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
                                               7'($urandom_range(0, 3));
    return c;
  endfunction

  // Drop valid, let every result drain, then a few quiet cycles
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Result checker: each accepted transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    lmt_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      sink_wait = pace_on ? $urandom_range(0, 5) : 0;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result expected none, got line %0d mode %0d", $time,
                   out_current_line, out_lcd_mode);
      end else begin
        want = pending_results.pop_front();
        check_field("copy_valid",    16'(want.copy_valid),    16'(out_copy_valid));
        check_field("copy_source",   want.copy_source,        out_copy_source);
        check_field("copy_dest",     want.copy_dest,          out_copy_dest);
        check_field("halt_out",      16'(want.halt_out),      16'(out_halt_out));
        check_field("current_line",  16'(want.current_line),  16'(out_current_line));
        check_field("lcd_mode",      16'(want.lcd_mode),      16'(out_lcd_mode));
        check_field("vblank_irq",    16'(want.vblank_irq),    16'(out_vblank_irq));
        check_field("stat_irq",      16'(want.stat_irq),      16'(out_stat_irq));
        check_field("coincident",    16'(want.coincident),    16'(out_coincident));
        check_field("frame_done",    16'(want.frame_done),    16'(out_frame_done));
        check_field("draw_row",      16'(want.draw_row),      16'(out_draw_row));
        check_field("dma_remaining", 16'(want.dma_remaining), 16'(out_dma_remaining));
      end
    end
  end

  // Result sink pacing, plus one long hold so the block backs up its input
  always @(negedge clk) begin
    if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      squeeze_done = 1'b1;
      sink_wait    = SQUEEZE_CYCLES;
    end
    out_stall <= (sink_wait != 0);
    if (sink_wait != 0) sink_wait--;
  end

  // Stimulus
  initial begin : stimulus
    lcd_cmd_t    c;
    int unsigned k;
    int unsigned p;
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_func       = FUNC_DOT;
    in_sub_step   = '0;
    in_cpu_halted = 1'b0;
    in_dma_source = '0;
    in_dma_dest   = '0;
    in_dma_blocks = '0;
    lcd_tim       = '0;
    lcd_regs      = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, LCD off then on
    for (k = 0; k < ON_FROM; k++)
      push_cmd(BOOT_ROWS[k].cmd, BOOT_ROWS[k].has_want, BOOT_ROWS[k].want);
    settle();
    load_regs(PHASE_REGS[0]);
    for (k = ON_FROM; k < ROWS; k++)
      push_cmd(BOOT_ROWS[k].cmd, BOOT_ROWS[k].has_want, BOOT_ROWS[k].want);

    // dot sweep without idling: crosses a line end with a long HBlank DMA
    settle();
    load_regs(PHASE_REGS[1]);
    pace_on  = 1'b0;
    c        = random_cmd(SWEEP_ODDS);
    c.func   = FUNC_HDMA;
    c.blocks = 7'h7f;
    push_cmd(c, 1'b0, '0);
    for (k = 0; k < SWEEP_ITEMS; k++)
      push_cmd(random_cmd(SWEEP_ODDS), 1'b0, '0);

    // random phases over the remaining register settings
    for (p = 0; p < 4; p++) begin
      settle();
      load_regs(PHASE_REGS[p + 2]);
      for (k = 0; k < PHASE_ITEMS[p]; k++) begin
        if (k % 50 == 0) pace_on = ($urandom_range(0, 3) != 0);
        push_cmd(random_cmd(RANDOM_ODDS), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
